[rtl/core/tcw_pkg.sv]
// shared constants, codes and types for the text console writer
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // field widths fixed by the interface
  localparam int KIND_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int POS_W    = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = CHAR_W + COLOR_W;

  // internal widths derived from the geometry
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CUR_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int WIDE_W = (CUR_W > POS_W) ? CUR_W : POS_W;

  // character codes and reset colour
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'd32;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h07;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 3'd0,
    KIND_CLEAR = 3'd1,
    KIND_BACK  = 3'd2,
    KIND_FWD   = 3'd3,
    KIND_SET   = 3'd4,
    KIND_READ  = 3'd5
  } kind_t;

  // cell store access, one write and one read per cycle
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

  // finished result from the sequencer
  typedef struct packed {
    logic                valid;
    logic [CURSOR_W-1:0] cursor;
    logic [CHAR_W-1:0]   cell_char;
    logic [COLOR_W-1:0]  cell_color;
  } res_t;

endpackage

[rtl/core/tcw_cell_ram.sv]
// character cell store with one write port and one registered read port
module tcw_cell_ram (
  input  logic                      clk,
  input  tcw_pkg::ram_req_t         req,
  output logic [tcw_pkg::CELL_W-1:0] rd_data_r
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule

[rtl/core/tcw_ctrl.sv]
// sequencer: cursor tracking, sweeps over the cell store, column search
module tcw_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcw_pkg::KIND_W-1:0]    kind,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tcw_pkg::POS_W-1:0]     position,
  input  logic [tcw_pkg::COLOR_W-1:0]   text_color,
  output tcw_pkg::ram_req_t             ram_req,
  input  logic [tcw_pkg::CELL_W-1:0]    ram_rd_data,
  output tcw_pkg::res_t                 res,
  input  logic                          res_ready
);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_MOD    = 8'b0000_1000,
    S_READ   = 8'b0001_0000,
    S_SCROLL = 8'b0010_0000,
    S_FILL   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [tcw_pkg::CUR_W-1:0]          cur_r, cur_nxt;
  logic [tcw_pkg::COL_W-1:0]          col_r, col_nxt;
  logic [tcw_pkg::CUR_W-1:0]          addr_r, addr_nxt;
  logic [tcw_pkg::CELL_W-1:0]         cell_r, cell_nxt;
  tcw_pkg::kind_t                     kind_r;
  logic [tcw_pkg::CHAR_W-1:0]         char_r;
  logic [tcw_pkg::POS_W-1:0]          pos_r;

  logic [tcw_pkg::CUR_W-1:0]          put_adv;
  logic [tcw_pkg::COL_W-1:0]          col_inc;
  logic [tcw_pkg::COL_W-1:0]          col_dec;
  logic [tcw_pkg::WIDE_W-1:0]         pos_ext;
  logic                               pos_hit;
  logic [tcw_pkg::CUR_W-1:0]          pos_clamp;
  logic [tcw_pkg::CELL_W-1:0]         blank_cell;

  // cursor arithmetic
  assign col_inc = (col_r == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) ?
                   '0 : col_r + tcw_pkg::COL_W'(1);
  assign col_dec = (col_r == '0) ?
                   tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1) : col_r - tcw_pkg::COL_W'(1);
  assign put_adv = (char_r == tcw_pkg::NEWLINE_CODE) ?
                   cur_r + tcw_pkg::CUR_W'(tcw_pkg::COLUMNS) - tcw_pkg::CUR_W'(col_r) :
                   cur_r + tcw_pkg::CUR_W'(1);
  assign pos_ext   = tcw_pkg::WIDE_W'(pos_r);
  assign pos_hit   = pos_ext < tcw_pkg::WIDE_W'(tcw_pkg::CELLS);
  assign pos_clamp = pos_hit ? tcw_pkg::CUR_W'(pos_ext) :
                     tcw_pkg::CUR_W'(tcw_pkg::CELLS - 1);
  assign blank_cell = {text_color, tcw_pkg::BLANK_CODE};

  // result towards the output register
  assign res.valid      = (state_r == S_DONE);
  assign res.cursor     = tcw_pkg::CURSOR_W'(cur_r);
  assign res.cell_char  = cell_r[tcw_pkg::CHAR_W-1:0];
  assign res.cell_color = cell_r[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
  assign in_ready       = (state_r == S_IDLE);

  // next state and store access
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    col_nxt   = col_r;
    addr_nxt  = addr_r;
    cell_nxt  = cell_r;
    ram_req   = '0;
    case (state_r)
      // clearing pass after reset
      S_INIT: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = addr_r[tcw_pkg::ADDR_W-1:0];
        ram_req.wr_data = '0;
        addr_nxt        = addr_r + tcw_pkg::CUR_W'(1);
        if (addr_r == tcw_pkg::CUR_W'(tcw_pkg::CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cell_nxt  = '0;
        state_nxt = S_DONE;
        case (kind_r)
          tcw_pkg::KIND_PUT: begin
            if (char_r == tcw_pkg::NEWLINE_CODE) begin
              col_nxt = '0;
            end else begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_addr = cur_r[tcw_pkg::ADDR_W-1:0];
              ram_req.wr_data = {text_color, char_r};
              col_nxt         = col_inc;
            end
            // passing the last cell scrolls the screen
            if (put_adv >= tcw_pkg::CUR_W'(tcw_pkg::CELLS)) begin
              cur_nxt   = put_adv - tcw_pkg::CUR_W'(tcw_pkg::COLUMNS);
              addr_nxt  = '0;
              state_nxt = S_SCROLL;
            end else begin
              cur_nxt = put_adv;
            end
          end
          tcw_pkg::KIND_CLEAR: begin
            cur_nxt   = '0;
            col_nxt   = '0;
            addr_nxt  = '0;
            state_nxt = S_FILL;
          end
          tcw_pkg::KIND_BACK: begin
            if (cur_r != '0) begin
              cur_nxt = cur_r - tcw_pkg::CUR_W'(1);
              col_nxt = col_dec;
            end
          end
          tcw_pkg::KIND_FWD: begin
            if (cur_r != tcw_pkg::CUR_W'(tcw_pkg::CELLS - 1)) begin
              cur_nxt = cur_r + tcw_pkg::CUR_W'(1);
              col_nxt = col_inc;
            end
          end
          tcw_pkg::KIND_SET: begin
            cur_nxt   = pos_clamp;
            addr_nxt  = pos_clamp;
            state_nxt = S_MOD;
          end
          tcw_pkg::KIND_READ: begin
            if (pos_hit) begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = pos_clamp[tcw_pkg::ADDR_W-1:0];
              state_nxt       = S_READ;
            end
          end
          default: begin
          end
        endcase
      end
      // column of a set cursor by repeated subtraction of a row
      S_MOD: begin
        if (addr_r >= tcw_pkg::CUR_W'(tcw_pkg::COLUMNS)) begin
          addr_nxt = addr_r - tcw_pkg::CUR_W'(tcw_pkg::COLUMNS);
        end else begin
          col_nxt   = tcw_pkg::COL_W'(addr_r);
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        cell_nxt  = ram_rd_data;
        state_nxt = S_DONE;
      end
      // row copy: read one row below, write the cell read in the previous cycle
      S_SCROLL: begin
        if (addr_r != tcw_pkg::CUR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS)) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = tcw_pkg::ADDR_W'(addr_r + tcw_pkg::CUR_W'(tcw_pkg::COLUMNS));
          addr_nxt        = addr_r + tcw_pkg::CUR_W'(1);
        end else begin
          state_nxt = S_FILL;
        end
        if (addr_r != '0) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = tcw_pkg::ADDR_W'(addr_r - tcw_pkg::CUR_W'(1));
          ram_req.wr_data = ram_rd_data;
        end
      end
      // blanks from the sweep address to the last cell
      S_FILL: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = addr_r[tcw_pkg::ADDR_W-1:0];
        ram_req.wr_data = blank_cell;
        addr_nxt        = addr_r + tcw_pkg::CUR_W'(1);
        if (addr_r == tcw_pkg::CUR_W'(tcw_pkg::CELLS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cur_r   <= '0;
      col_r   <= '0;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      col_r   <= col_nxt;
      addr_r  <= addr_nxt;
    end
  end

  // item and read data registers
  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (in_valid && in_ready) begin
      kind_r <= tcw_pkg::kind_t'(kind);
      char_r <= char_code;
      pos_r  <= position;
    end
  end

endmodule

[rtl/core/text_console_writer.sv]
// text console writer top level: stream ports, colour register, output register
// path: an accepted item passes S_EXEC and S_DONE into the output register for put char,
//   cursor moves and unused kinds; read cell on the screen adds S_READ; set cursor adds S_MOD
// flow: one transaction in flight, next input taken only after the result has entered the
//   output register; a put char that scrolls also passes S_SCROLL and S_FILL, clear S_FILL
// reset: all CELLS (2000 here) cells of the store are swept to zero in S_INIT with
//   in_tready low; cursor 0 and text colour 0x07 at once
module text_console_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], position[18:8], zero pad
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cursor[10:0], cell_char[18:11], cell_color[26:19], pad
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int OUT_BITS = tcw_pkg::CURSOR_W + tcw_pkg::CHAR_W + tcw_pkg::COLOR_W;

  logic [tcw_pkg::COLOR_W-1:0]  text_color_r;
  tcw_pkg::ram_req_t            ram_req;
  logic [tcw_pkg::CELL_W-1:0]   ram_rd_data;
  tcw_pkg::res_t                res;
  logic                         res_load;
  logic                         out_valid_r;
  logic [OUT_BITS-1:0]          out_data_r;

  // colour register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcw_pkg::COLOR_RESET;
    end else if (cfg_wr_en) begin
      text_color_r <= cfg_wr_data;
    end
  end

  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .kind       (in_tuser),
    .char_code  (in_tdata[7:0]),
    .position   (in_tdata[18:8]),
    .text_color (text_color_r),
    .ram_req    (ram_req),
    .ram_rd_data(ram_rd_data),
    .res        (res),
    .res_ready  (res_load)
  );

  tcw_cell_ram u_cell_ram (
    .clk      (clk),
    .req      (ram_req),
    .rd_data_r(ram_rd_data)
  );

  // output register, loads when empty or being drained
  assign res_load = res.valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= {res.cell_color, res.cell_char, res.cursor};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32 - OUT_BITS){1'b0}}, out_data_r};

endmodule

[rtl/core/tcw_checker.sv]
// port-level checks for the text console writer and their binding
module tcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // reset leaves nothing to take and no room while the store is swept
  assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ready or valid straight after reset");

  // one transaction at a time: no acceptance in the cycle after one
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted back to back");

  // reported cursor stays on the screen
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($unsigned(out_tdata[10:0]) < tcw_pkg::CELLS))
    else $error("cursor beyond last cell");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
